[sv/rational_add_reduce_unit_assert.svh]
// Assertion macros for the rational add/reduce unit.
`ifndef RATIONAL_ADD_REDUCE_UNIT_ASSERT_SVH
`define RATIONAL_ADD_REDUCE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RAR_ASSERT_IMPL(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rational_add_reduce_unit: check failed");
`define RAR_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rational_add_reduce_unit: check failed");
`else
`define RAR_ASSERT_IMPL(label, ck, rs, ante, cons)
`define RAR_ASSERT_NEXT(label, ck, rs, ante, cons)
`endif
`endif

[sv/rar_pkg.sv]
`timescale 1ns / 1ps
package rar_pkg;
  localparam int OPERAND_BITS_DEF = 16;
  localparam int RES_NUM_W        = 33;
  localparam int RES_DEN_W        = 32;
endpackage

[sv/rational_add_reduce_unit.sv]
`timescale 1ns / 1ps
// Rational add/reduce unit.
// Input channel: in_valid / in_stall with req_type, num_a, den_a, num_b, den_b.
// req_type 0 puts num_a/den_a in lowest terms; req_type 1 adds the two fractions
// and puts the sum in lowest terms. A zero denominator that is used gives
// div_zero = 1 with res_num = res_den = 0.
// Output channel: out_valid / out_stall with res_num, res_den, div_zero.
// The unit is a fully pipelined datapath: while the output is not stalled, one
// item may enter every cycle and one result leaves per cycle. The pipe holds
// stage A, stage B, GS = NW + DW binary-GCD step stages, a shift stage and NW
// restoring-division stages; NW is the sum width (2*OPERAND_BITS+1, at most 64)
// and DW = 2*OPERAND_BITS (33, 32 at default); the GCD chain is the longest part.
// Reset clears every valid bit in the pipe; payload registers are not reset.
// When the receiver stalls with a result waiting, the whole pipe holds and
// in_stall rises in the same cycle; no item is lost or repeated.
`include "rational_add_reduce_unit_assert.svh"
module rational_add_reduce_unit #(
  parameter int OPERAND_BITS = rar_pkg::OPERAND_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [OPERAND_BITS-1:0]       num_a,
  input  logic [OPERAND_BITS-1:0]       den_a,
  input  logic [OPERAND_BITS-1:0]       num_b,
  input  logic [OPERAND_BITS-1:0]       den_b,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rar_pkg::RES_NUM_W-1:0] res_num,
  output logic [rar_pkg::RES_DEN_W-1:0] res_den,
  output logic                          div_zero
);
  import rar_pkg::*;

  localparam int W  = OPERAND_BITS;
  localparam int NW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;  // numerator width
  localparam int DW = 2 * W;                             // denominator width
  localparam int GS = NW + DW;                           // GCD step stages
  localparam int KW = $clog2(DW + 1);                    // shared power of two

  // The whole pipe advances together unless a finished result is held.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage A: register operands and the three products.
  logic          a_vld, a_add, a_eq, a_dz;
  logic [W-1:0]  a_na, a_nb, a_da;
  logic [DW-1:0] a_pa, a_pb, a_pd;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= in_valid;
    end
    if (adv) begin
      a_add <= req_type;
      a_eq  <= (den_a == den_b);
      a_dz  <= (den_a == '0) || (req_type && (den_b == '0));
      a_na  <= num_a;
      a_nb  <= num_b;
      a_da  <= den_a;
      a_pa  <= DW'(num_a) * DW'(den_b);
      a_pb  <= DW'(num_b) * DW'(den_a);
      a_pd  <= DW'(den_a) * DW'(den_b);
    end
  end

  // Stage B: form the unreduced fraction. Zero numerator and a zero
  // denominator both become 0/1, which the GCD passes unchanged.
  logic [DW:0]   sum_cross, sum_eq;
  logic [NW-1:0] b_n_next;
  logic [DW-1:0] b_d_next;

  always_comb begin
    sum_cross = {1'b0, a_pa} + {1'b0, a_pb};
    sum_eq    = (DW + 1)'(a_na) + (DW + 1)'(a_nb);
    if (!a_add) begin
      b_n_next = NW'(a_na);
      b_d_next = DW'(a_da);
    end else if (a_eq) begin
      b_n_next = NW'(sum_eq);
      b_d_next = DW'(a_da);
    end else begin
      b_n_next = NW'(sum_cross);
      b_d_next = a_pd;
    end
    if (a_dz || (b_n_next == '0)) begin
      b_n_next = '0;
      b_d_next = DW'(1);
    end
  end

  // GCD chain: index 0 is stage B's register.
  logic          g_vld [GS+1];
  logic          g_dz  [GS+1];
  logic [NW-1:0] g_n   [GS+1];
  logic [DW-1:0] g_d   [GS+1];
  logic [NW-1:0] g_u   [GS+1];
  logic [DW-1:0] g_v   [GS+1];
  logic [KW-1:0] g_k   [GS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld[0] <= 1'b0;
    end else if (adv) begin
      g_vld[0] <= a_vld;
    end
    if (adv) begin
      g_dz[0] <= a_dz;
      g_n[0]  <= b_n_next;
      g_d[0]  <= b_d_next;
      g_u[0]  <= b_n_next;
      g_v[0]  <= b_d_next;
      g_k[0]  <= '0;
    end
  end

  // One binary GCD step per stage; each step drops at least one bit of
  // u and v together, so u reaches zero by the end of the chain.
  for (genvar i = 0; i < GS; i++) begin : g_gcd
    logic [NW-1:0] u_next;
    logic [DW-1:0] v_next;
    logic [KW-1:0] k_next;
    logic [NW-1:0] diff_uv;
    logic [DW-1:0] diff_vu;

    always_comb begin
      diff_uv = g_u[i] - NW'(g_v[i]);
      diff_vu = g_v[i] - DW'(g_u[i]);
      u_next  = g_u[i];
      v_next  = g_v[i];
      k_next  = g_k[i];
      if (g_u[i] == '0) begin
        u_next = '0;
      end else if (!g_u[i][0] && !g_v[i][0]) begin
        u_next = g_u[i] >> 1;
        v_next = g_v[i] >> 1;
        k_next = g_k[i] + KW'(1);
      end else if (!g_u[i][0]) begin
        u_next = g_u[i] >> 1;
      end else if (!g_v[i][0]) begin
        v_next = g_v[i] >> 1;
      end else if (g_u[i] >= NW'(g_v[i])) begin
        u_next = diff_uv >> 1;
      end else begin
        v_next = diff_vu >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        g_vld[i+1] <= 1'b0;
      end else if (adv) begin
        g_vld[i+1] <= g_vld[i];
      end
      if (adv) begin
        g_dz[i+1] <= g_dz[i];
        g_n[i+1]  <= g_n[i];
        g_d[i+1]  <= g_d[i];
        g_u[i+1]  <= u_next;
        g_v[i+1]  <= v_next;
        g_k[i+1]  <= k_next;
      end
    end
  end

  // Shift stage: strip the shared power of two; v holds the odd part.
  logic          s_vld, s_dz;
  logic [NW-1:0] s_n;
  logic [NW-1:0] s_d;
  logic [DW-1:0] s_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else if (adv) begin
      s_vld <= g_vld[GS];
    end
    if (adv) begin
      s_dz <= g_dz[GS];
      s_n  <= g_n[GS] >> g_k[GS];
      s_d  <= NW'(g_d[GS] >> g_k[GS]);
      s_v  <= g_v[GS];
    end
  end

  // Restoring division of both parts by the odd factor, one bit per stage.
  logic          q_vld [NW+1];
  logic          q_dz  [NW+1];
  logic [NW-1:0] q_nn  [NW+1];  // numerator dividend
  logic [NW-1:0] q_dd  [NW+1];  // denominator dividend
  logic [NW-1:0] q_nq  [NW+1];
  logic [NW-1:0] q_dq  [NW+1];
  logic [DW-1:0] q_nr  [NW+1];
  logic [DW-1:0] q_dr  [NW+1];
  logic [DW-1:0] q_v   [NW+1];

  assign q_vld[0] = s_vld;
  assign q_dz[0]  = s_dz;
  assign q_nn[0]  = s_n;
  assign q_dd[0]  = s_d;
  assign q_nq[0]  = '0;
  assign q_dq[0]  = '0;
  assign q_nr[0]  = '0;
  assign q_dr[0]  = '0;
  assign q_v[0]   = s_v;

  for (genvar j = 0; j < NW; j++) begin : g_div
    logic [DW:0] nt, dt;
    logic        nge, dge;

    always_comb begin
      nt  = {q_nr[j], q_nn[j][NW-1-j]};
      dt  = {q_dr[j], q_dd[j][NW-1-j]};
      nge = (nt >= {1'b0, q_v[j]});
      dge = (dt >= {1'b0, q_v[j]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        q_vld[j+1] <= 1'b0;
      end else if (adv) begin
        q_vld[j+1] <= q_vld[j];
      end
      if (adv) begin
        q_dz[j+1] <= q_dz[j];
        q_nn[j+1] <= q_nn[j];
        q_dd[j+1] <= q_dd[j];
        q_v[j+1]  <= q_v[j];
        q_nq[j+1] <= {q_nq[j][NW-2:0], nge};
        q_dq[j+1] <= {q_dq[j][NW-2:0], dge};
        q_nr[j+1] <= nge ? DW'(nt - {1'b0, q_v[j]}) : DW'(nt);
        q_dr[j+1] <= dge ? DW'(dt - {1'b0, q_v[j]}) : DW'(dt);
      end
    end
  end

  // Result: the last division stage is the output register.
  localparam int OVN = (NW > RES_NUM_W) ? NW : RES_NUM_W;
  localparam int OVD = (NW > RES_DEN_W) ? NW : RES_DEN_W;
  logic [OVN-1:0] wide_n;
  logic [OVD-1:0] wide_d;

  assign wide_n    = OVN'(q_nq[NW]);
  assign wide_d    = OVD'(q_dq[NW]);
  assign out_valid = q_vld[NW];
  assign div_zero  = q_dz[NW];
  assign res_num   = q_dz[NW] ? '0 : wide_n[RES_NUM_W-1:0];
  assign res_den   = q_dz[NW] ? '0 : wide_d[RES_DEN_W-1:0];

  `RAR_ASSERT_IMPL(a_gcd_done, clk, rst, g_vld[GS], g_u[GS] == '0)
  `RAR_ASSERT_IMPL(a_gcd_odd, clk, rst, g_vld[GS], g_v[GS] != '0 && g_v[GS][0])
  `RAR_ASSERT_IMPL(a_dz_zero, clk, rst, out_valid && div_zero,
                   res_num == '0 && res_den == '0)
  `RAR_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall,
                   out_valid && $stable(q_nq[NW]) && $stable(q_dq[NW]))
endmodule

[verif/rational_add_reduce_unit_test.sv]
`timescale 1ns / 1ps
module rational_add_reduce_unit_test;
  import rar_pkg::*;

  localparam int OB = OPERAND_BITS_DEF;
  // Extra settle time at the end, longer than the pipe depth at the default width.
  localparam int DRAIN_CYCLES = 300;
  localparam longint CYCLE_LIMIT = 2000000;

  // Request kinds as carried on req_type.
  typedef enum logic {REQ_REDUCE = 1'b0, REQ_ADD = 1'b1} req_kind_t;

  typedef struct packed {
    logic [RES_NUM_W-1:0] num;
    logic [RES_DEN_W-1:0] den;
    logic                 dz;
  } fraction_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic [OB-1:0] num_a = '0, den_a = '0, num_b = '0, den_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RES_NUM_W-1:0] res_num;
  logic [RES_DEN_W-1:0] res_den;
  logic div_zero;

  fraction_t sum_queue[$];
  int  error_count = 0;
  int  sender_idle_pct = 0;
  int  receiver_stall_pct = 0;
  longint cycle_count = 0;

  rational_add_reduce_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .num_a(num_a), .den_a(den_a), .num_b(num_b), .den_b(den_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_num(res_num), .res_den(res_den), .div_zero(div_zero)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Euclid on 64-bit values; second argument is nonzero on every call.
  function automatic logic [63:0] common_factor(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Work out the lowest-terms fraction the block should return for one item.
  function automatic fraction_t lowest_terms(req_kind_t kind, logic [OB-1:0] na,
                                             logic [OB-1:0] da, logic [OB-1:0] nb,
                                             logic [OB-1:0] db);
    fraction_t f;
    logic [63:0] n, d, g;
    f = '0;
    if (da == 0 || (kind == REQ_ADD && db == 0)) begin
      f.dz = 1'b1;
      return f;
    end
    if (kind == REQ_REDUCE) begin
      n = 64'(na);
      d = 64'(da);
    end else if (da == db) begin
      n = 64'(na) + 64'(nb);
      d = 64'(da);
    end else begin
      n = 64'(na) * 64'(db) + 64'(nb) * 64'(da);
      d = 64'(da) * 64'(db);
    end
    if (n == 0) begin
      d = 1;
    end else if (n == d) begin
      n = 1;
      d = 1;
    end else begin
      g = common_factor(n, d);
      n = n / g;
      d = d / g;
    end
    f.num = n[RES_NUM_W-1:0];
    f.den = d[RES_DEN_W-1:0];
    return f;
  endfunction

  // Present one item, hold it until accepted, and queue its expected fraction.
  // Valid stays high after acceptance so the next item can follow at once.
  task automatic send_item(req_kind_t kind, logic [OB-1:0] na, logic [OB-1:0] da,
                           logic [OB-1:0] nb, logic [OB-1:0] db);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    num_a <= na;
    den_a <= da;
    num_b <= nb;
    den_b <= db;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sum_queue.push_back(lowest_terms(kind, na, da, nb, db));
    @(negedge clk);
  endtask

  // Randomize stall on the falling edge so it is stable at the sampling edge.
  always @(negedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    fraction_t exp_f;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      if (sum_queue.size() == 0) begin
        $display("%0t: unexpected result num=%0d den=%0d dz=%0b",
                 $time, res_num, res_den, div_zero);
        error_count++;
      end else begin
        exp_f = sum_queue.pop_front();
        if (res_num !== exp_f.num || res_den !== exp_f.den || div_zero !== exp_f.dz) begin
          $display("%0t: mismatch expected %0d/%0d dz=%0b actual %0d/%0d dz=%0b",
                   $time, exp_f.num, exp_f.den, exp_f.dz, res_num, res_den, div_zero);
          error_count++;
        end
      end
    end
  end

  // Give up on a hung pipe.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [OB-1:0] rand_opnd();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return OB'($urandom_range(15));
      3: return OB'($urandom_range(255) * 8);
      default: return OB'($urandom);
    endcase
  endfunction

  // Extremes, both operations, and each special case.
  task automatic test_directed();
    send_item(REQ_REDUCE, 0, 7, 0, 0);         // zero numerator
    send_item(REQ_REDUCE, 5, 0, 3, 3);         // zero denominator
    send_item(REQ_REDUCE, 9, 6, 1, 0);         // den_b ignored when reducing
    send_item(REQ_REDUCE, 1234, 1234, 0, 0);   // equal parts
    send_item(REQ_REDUCE, 7, 9, 0, 0);         // coprime, passes unchanged
    send_item(REQ_REDUCE, '1, '1, '1, '1);
    send_item(REQ_REDUCE, '1, 1, 0, 0);
    send_item(REQ_REDUCE, 1, '1, 0, 0);
    send_item(REQ_REDUCE, 16'h8000, 16'h4000, 0, 0);
    send_item(REQ_ADD, 1, 2, 1, 2);            // equal denominators
    send_item(REQ_ADD, 1, 3, 1, 6);
    send_item(REQ_ADD, 0, 5, 0, 9);            // zero sum
    send_item(REQ_ADD, 3, 4, 1, 0);            // zero den_b
    send_item(REQ_ADD, 3, 0, 1, 4);            // zero den_a
    send_item(REQ_ADD, 0, 0, 0, 0);
    send_item(REQ_ADD, '1, '1, '1, '1);
    send_item(REQ_ADD, '1, 1, '1, 1);
    send_item(REQ_ADD, '1, 16'hFFFE, '1, 16'hFFFD); // widest cross sum
    send_item(REQ_ADD, 1, 2, 1, 3);            // sum 5/6, coprime
    send_item(REQ_ADD, 2, 3, 1, 3);            // sum equals 1
    send_item(REQ_ADD, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      send_item($urandom_range(1) ? REQ_ADD : REQ_REDUCE,
                rand_opnd(), rand_opnd(), rand_opnd(), rand_opnd());
    end
  endtask

  // Drop valid, hold until every expected result is back, then let the pipe settle.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sum_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(250);

    sender_idle_pct = 62;
    test_random(250);

    sender_idle_pct = 0;
    receiver_stall_pct = 62;
    test_random(250);

    sender_idle_pct = 32;
    receiver_stall_pct = 32;
    test_random(250);

    wait_drain();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

[rational_add_reduce_unit.f]
+incdir+sv
sv/rar_pkg.sv
sv/rational_add_reduce_unit.sv
verif/rational_add_reduce_unit_test.sv
